>>> rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define SHF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SHF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SHF_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define SHF_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/shfsm_pkg.sv
// types and constants of the handshake engine
package shfsm_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [7:0]  CH_C          = 8'h43;
    localparam logic [7:0]  CH_A          = 8'h41;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    localparam logic [1:0] REG_ROLE    = 2'd0;
    localparam logic [1:0] REG_OWN     = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    typedef struct packed {
        logic        role;
        logic [7:0]  own_value;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic       tx_valid;
        logic       two;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       done_res;
        logic [7:0] partner_value;
    } res_t;

endpackage

>>> rtl/shfsm_in_if.sv
// input channel: request words
interface shfsm_in_if;
    import shfsm_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

>>> rtl/shfsm_out_if.sv
// output channel: result words
interface shfsm_out_if;
    import shfsm_pkg::*;

    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       done_res;
    logic [7:0] partner_value;
    logic       last;

    modport source (
        output valid, output tx_valid, output tx_byte, output done_res,
        output partner_value, output last, input ready
    );
    modport sink (
        input valid, input tx_valid, input tx_byte, input done_res,
        input partner_value, input last, output ready
    );
endinterface

>>> rtl/shfsm_cfg.sv
// apb register block: role, own value and timeout
module shfsm_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [shfsm_pkg::ADDR_W-1:0] paddr,
    input  logic [shfsm_pkg::DATA_W-1:0] pwdata,
    output logic [shfsm_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output shfsm_pkg::cfg_t             cfg
);
    import shfsm_pkg::*;

    logic        role_reg;
    logic [7:0]  own_reg;
    logic [15:0] timeout_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_reg    <= 1'b0;
            own_reg     <= 8'd0;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ROLE:    role_reg    <= pwdata[0];
                REG_OWN:     own_reg     <= pwdata[7:0];
                REG_TIMEOUT: timeout_reg <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ROLE:    prdata = {{(DATA_W-1){1'b0}}, role_reg};
            REG_OWN:     prdata = {{(DATA_W-8){1'b0}}, own_reg};
            REG_TIMEOUT: prdata = {{(DATA_W-16){1'b0}}, timeout_reg};
            default:     prdata = '0;
        endcase
    end

    assign cfg.role          = role_reg;
    assign cfg.own_value     = own_reg;
    assign cfg.timeout_ticks = timeout_reg;
endmodule

>>> rtl/shfsm_core.sv
// input register and handshake state machine
module shfsm_core (
    input  logic            clk,
    input  logic            rst_n,
    shfsm_in_if.sink        in_word,
    input  shfsm_pkg::cfg_t cfg,
    input  logic            free,
    output shfsm_pkg::res_t res
);
    import shfsm_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_C_ACK,
        PH_C_VAL,
        PH_S_LIST,
        PH_S_VAL,
        PH_S_ACK,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] wait_reg, wait_next, wait_inc;
    logic [7:0]  recv_reg, recv_next;
    logic        in_valid_reg;
    logic [1:0]  req_reg;
    logic [7:0]  rx_reg;
    logic        advance;
    logic        waiting;
    logic        tx_v;
    logic        two;
    logic [7:0]  first_byte;

    assign advance       = in_valid_reg && free;
    assign in_word.ready = !in_valid_reg || free;
    assign waiting       = (phase_reg != PH_IDLE) && (phase_reg != PH_DONE);
    assign wait_inc      = wait_reg + 16'd1;

    always_comb
    begin
        phase_next = phase_reg;
        wait_next  = wait_reg;
        recv_next  = recv_reg;
        tx_v       = 1'b0;
        two        = 1'b0;
        first_byte = 8'd0;
        unique case (req_reg)
            REQ_START:
            begin
                wait_next = 16'd0;
                if (cfg.role)
                begin
                    phase_next = PH_C_ACK;
                    tx_v       = 1'b1;
                    two        = 1'b1;
                    first_byte = CH_C;
                end
                else
                begin
                    phase_next = PH_S_LIST;
                end
            end
            REQ_BYTE:
            begin
                if (waiting)
                begin
                    wait_next = 16'd0;
                    unique case (phase_reg)
                        PH_C_ACK:
                        begin
                            if (rx_reg == CH_A)
                                phase_next = PH_C_VAL;
                        end
                        PH_C_VAL:
                        begin
                            recv_next  = rx_reg;
                            phase_next = PH_DONE;
                            tx_v       = 1'b1;
                            first_byte = CH_A;
                        end
                        PH_S_LIST:
                        begin
                            if (rx_reg == CH_C)
                                phase_next = PH_S_VAL;
                        end
                        PH_S_VAL:
                        begin
                            recv_next  = rx_reg;
                            phase_next = PH_S_ACK;
                            tx_v       = 1'b1;
                            two        = 1'b1;
                            first_byte = CH_A;
                        end
                        PH_S_ACK:
                        begin
                            if (rx_reg == CH_A)
                                phase_next = PH_DONE;
                        end
                        default: ;
                    endcase
                end
            end
            REQ_TICK:
            begin
                if (waiting)
                begin
                    wait_next = wait_inc;
                    if (wait_inc >= cfg.timeout_ticks)
                    begin
                        wait_next = 16'd0;
                        priority if (phase_reg == PH_C_ACK)
                        begin
                            tx_v       = 1'b1;
                            two        = 1'b1;
                            first_byte = CH_C;
                        end
                        else if (phase_reg == PH_C_VAL)
                        begin
                            phase_next = PH_C_ACK;
                        end
                        else
                        begin
                            phase_next = PH_S_LIST;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign res.valid         = in_valid_reg;
    assign res.tx_valid      = tx_v;
    assign res.two           = two;
    assign res.first_byte    = first_byte;
    assign res.second_byte   = cfg.own_value;
    assign res.done_res      = (phase_next == PH_DONE);
    assign res.partner_value = (phase_next == PH_DONE) ? recv_next : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
            wait_reg     <= 16'd0;
            recv_reg     <= 8'd0;
            req_reg      <= REQ_TICK;
            rx_reg       <= 8'd0;
        end
        else
        begin
            if (in_word.ready)
            begin
                in_valid_reg <= in_word.valid;
                req_reg      <= in_word.req_type;
                rx_reg       <= in_word.rx_byte;
            end
            if (advance)
            begin
                phase_reg <= phase_next;
                wait_reg  <= wait_next;
                recv_reg  <= recv_next;
            end
        end
    end
endmodule

>>> rtl/shfsm_out.sv
// result register: sends one or two words per request
module shfsm_out (
    input  logic            clk,
    input  logic            rst_n,
    input  shfsm_pkg::res_t res,
    output logic            free,
    shfsm_out_if.source     out_word
);
    import shfsm_pkg::*;

    res_t res_reg;
    logic full_reg;
    logic idx_reg;
    logic take;
    logic word_last;

    assign word_last = idx_reg || !res_reg.two;
    assign take      = full_reg && out_word.ready;
    assign free      = !full_reg || (take && word_last);

    assign out_word.valid         = full_reg;
    assign out_word.tx_valid      = idx_reg ? 1'b1 : res_reg.tx_valid;
    assign out_word.tx_byte       = idx_reg ? res_reg.second_byte : res_reg.first_byte;
    assign out_word.done_res      = res_reg.done_res;
    assign out_word.partner_value = res_reg.partner_value;
    assign out_word.last          = word_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            idx_reg  <= 1'b0;
        end
        else if (free)
        begin
            full_reg <= res.valid;
            idx_reg  <= 1'b0;
            if (res.valid)
                res_reg <= res;
        end
        else if (take)
        begin
            idx_reg <= 1'b1;
        end
    end
endmodule

>>> rtl/serial_handshake_fsm_unit.sv
// top level of the two-way byte exchange handshake engine
// A request word enters an input register, the state machine works on it combinationally and
// the words it produces go to a result register, from which a result is offered downstream.
// A request that produces one word leaves the result register when that word is taken; one
// that sends two bytes ('C' or 'A' then the own value) holds the single result register until
// its second word is taken. Requests are taken at one per cycle while the downstream side
// takes every word, and a new request waits while such a pair goes out. The result register
// and the input register keep taking requests while the downstream side stalls until both
// hold a word. Registers are written through the apb port.
`include "assert_macros.svh"

module serial_handshake_fsm_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    shfsm_in_if.sink                    in_word,
    shfsm_out_if.source                 out_word,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [shfsm_pkg::ADDR_W-1:0] paddr,
    input  logic [shfsm_pkg::DATA_W-1:0] pwdata,
    output logic [shfsm_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import shfsm_pkg::*;

    cfg_t cfg;
    res_t core_res;
    logic free;

    shfsm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    shfsm_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_word (in_word),
        .cfg     (cfg),
        .free    (free),
        .res     (core_res)
    );

    shfsm_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (core_res),
        .free     (free),
        .out_word (out_word)
    );

    // first of a pair always carries a byte
    `SHF_ASSERT_IMP(a_pair_tx, clk, rst_n, out_word.valid && !out_word.last, out_word.tx_valid)
    // second word of a pair follows at once
    `SHF_ASSERT_NXT(a_pair_next, clk, rst_n, out_word.valid && out_word.ready && !out_word.last,
                    out_word.valid && out_word.last && out_word.tx_valid)
    `SHF_ASSERT_IMP(a_partner_zero, clk, rst_n, out_word.valid && !out_word.done_res,
                    out_word.partner_value == 8'd0)
    // input only stalls behind a held request
    `SHF_ASSERT_IMP(a_in_stall, clk, rst_n, !in_word.ready, core_res.valid && !free)
endmodule

>>> tb/tb_serial_handshake_fsm_unit.sv
// testbench for the byte handshake engine: directed and random request words checked against a predictor
`timescale 1ns / 100ps

module tb_serial_handshake_fsm_unit;
    import shfsm_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 1300;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLI_ACK,
        ST_CLI_VAL,
        ST_SRV_LISTEN,
        ST_SRV_VAL,
        ST_SRV_ACK,
        ST_DONE
    } hs_state_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       done_res;
        logic [7:0] partner_value;
        logic       last;
    } word_t;

    class handshake_scoreboard;
        logic        role;
        logic [7:0]  own_value;
        logic [15:0] timeout_ticks;
        hs_state_t   state;
        logic [15:0] wait_count;
        logic [7:0]  partner;
        word_t       pending_words[$];
        int          mismatch_count;

        function new();
            role = 1'b0;
            own_value = 8'h00;
            timeout_ticks = TIMEOUT_RESET;
            state = ST_IDLE;
            wait_count = 16'd0;
            partner = 8'h00;
            mismatch_count = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_ROLE:    role = value[0];
                REG_OWN:     own_value = value[7:0];
                REG_TIMEOUT: timeout_ticks = value[15:0];
                default:     ;
            endcase
        endfunction

        function void push_word(logic tx_valid, logic [7:0] tx_byte, logic is_last);
            word_t w;
            w.tx_valid = tx_valid;
            w.tx_byte = tx_valid ? tx_byte : 8'h00;
            w.done_res = (state == ST_DONE);
            w.partner_value = (state == ST_DONE) ? partner : 8'h00;
            w.last = is_last;
            pending_words.push_back(w);
        endfunction

        function void note_request(logic [1:0] req, logic [7:0] rx);
            logic       waiting;
            logic [7:0] first;
            int         n_tx;
            waiting = (state != ST_IDLE) && (state != ST_DONE);
            first = 8'h00;
            n_tx = 0;
            if (req == REQ_START)
            begin
                wait_count = 16'd0;
                if (role)
                begin
                    state = ST_CLI_ACK;
                    first = CH_C;
                    n_tx = 2;
                end
                else
                begin
                    state = ST_SRV_LISTEN;
                end
            end
            else if (req == REQ_BYTE && waiting)
            begin
                wait_count = 16'd0;
                case (state)
                    ST_CLI_ACK:
                    begin
                        if (rx == CH_A)
                            state = ST_CLI_VAL;
                    end
                    ST_CLI_VAL:
                    begin
                        partner = rx;
                        state = ST_DONE;
                        first = CH_A;
                        n_tx = 1;
                    end
                    ST_SRV_LISTEN:
                    begin
                        if (rx == CH_C)
                            state = ST_SRV_VAL;
                    end
                    ST_SRV_VAL:
                    begin
                        partner = rx;
                        state = ST_SRV_ACK;
                        first = CH_A;
                        n_tx = 2;
                    end
                    default:
                    begin
                        if (rx == CH_A)
                            state = ST_DONE;
                    end
                endcase
            end
            else if (req == REQ_TICK && waiting)
            begin
                wait_count = wait_count + 16'd1;
                if (wait_count >= timeout_ticks)
                begin
                    wait_count = 16'd0;
                    if (state == ST_CLI_ACK)
                    begin
                        first = CH_C;
                        n_tx = 2;
                    end
                    else if (state == ST_CLI_VAL)
                    begin
                        state = ST_CLI_ACK;
                    end
                    else
                    begin
                        state = ST_SRV_LISTEN;
                    end
                end
            end
            if (n_tx == 0)
            begin
                push_word(1'b0, 8'h00, 1'b1);
            end
            else if (n_tx == 1)
            begin
                push_word(1'b1, first, 1'b1);
            end
            else
            begin
                push_word(1'b1, first, 1'b0);
                push_word(1'b1, own_value, 1'b1);
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_word(word_t got);
            word_t want;
            if (pending_words.size() == 0)
            begin
                $error("unexpected word: tx_valid %0d tx_byte %0h done_res %0d last %0d",
                       got.tx_valid, got.tx_byte, got.done_res, got.last);
                mismatch_count++;
                return;
            end
            want = pending_words.pop_front();
            compare_field("tx_valid", want.tx_valid, got.tx_valid);
            compare_field("tx_byte", want.tx_byte, got.tx_byte);
            compare_field("done_res", want.done_res, got.done_res);
            compare_field("partner_value", want.partner_value, got.partner_value);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    shfsm_in_if  in_w();
    shfsm_out_if out_w();

    handshake_scoreboard sb;
    int unsigned         burst_left;
    int unsigned         items_sent;
    logic                cur_role;

    serial_handshake_fsm_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_w),
        .out_word (out_w),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    task automatic send_req(input logic [1:0] req, input logic [7:0] rx);
        in_w.valid <= 1'b1;
        in_w.req_type <= req;
        in_w.rx_byte <= rx;
        @(posedge clk);
        while (!in_w.ready)
            @(posedge clk);
        sb.note_request(req, rx);
    endtask

    task automatic issue(input logic [1:0] req, input logic [7:0] rx);
        if (burst_left == 0)
        begin
            in_w.valid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        send_req(req, rx);
        if (req != REQ_UNUSED)
            items_sent++;
    endtask

    task automatic drain();
        in_w.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic noise();
        int unsigned n;
        int unsigned r;
        n = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3);
        repeat (n)
        begin
            r = $urandom_range(0, 19);
            if (r < 12)
                issue(REQ_TICK, 8'($urandom_range(0, 255)));
            else if (r < 17)
                issue(REQ_BYTE, 8'($urandom_range(0, 255)));
            else if (r < 19)
                issue(REQ_UNUSED, 8'($urandom_range(0, 255)));
            else
                issue(REQ_START, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_session();
        logic [7:0]  steps[3];
        int unsigned n_steps;
        issue(REQ_START, 8'($urandom_range(0, 255)));
        if (cur_role)
        begin
            steps[0] = CH_A;
            steps[1] = 8'($urandom_range(0, 255));
            n_steps = 2;
        end
        else
        begin
            steps[0] = CH_C;
            steps[1] = 8'($urandom_range(0, 255));
            steps[2] = CH_A;
            n_steps = 3;
        end
        for (int unsigned i = 0; i < n_steps; i++)
        begin
            noise();
            if ($urandom_range(0, 19) == 0)
                return;
            issue(REQ_BYTE, steps[i]);
        end
        if ($urandom_range(0, 3) == 0)
            issue(2'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    task automatic directed_part();
        send_req(REQ_TICK, 8'hFF);
        send_req(REQ_BYTE, CH_C);
        send_req(REQ_UNUSED, 8'h00);
        send_req(REQ_START, 8'h00);
        send_req(REQ_BYTE, 8'h58);
        send_req(REQ_BYTE, CH_C);
        send_req(REQ_BYTE, 8'hFF);
        send_req(REQ_BYTE, 8'h42);
        send_req(REQ_BYTE, CH_A);
        send_req(REQ_TICK, 8'h00);
        drain();
        write_reg(REG_ROLE, 32'd1);
        write_reg(REG_OWN, 32'hFF);
        write_reg(REG_TIMEOUT, 32'd1);
        send_req(REQ_START, 8'h00);
        send_req(REQ_TICK, 8'h00);
        send_req(REQ_BYTE, CH_A);
        send_req(REQ_TICK, 8'h00);
        send_req(REQ_BYTE, CH_A);
        send_req(REQ_BYTE, 8'h00);
        send_req(REQ_START, 8'hFF);
        send_req(REQ_UNUSED, 8'hFF);
        drain();
        // role change while the client waits for the ack, then a zero timeout
        write_reg(REG_ROLE, 32'd0);
        write_reg(REG_TIMEOUT, 32'd0);
        send_req(REQ_TICK, 8'h00);
        send_req(REQ_START, 8'h00);
        send_req(REQ_BYTE, CH_C);
        send_req(REQ_TICK, 8'h00);
        send_req(REQ_BYTE, CH_C);
        send_req(REQ_BYTE, 8'h5A);
        send_req(REQ_TICK, 8'h00);
        drain();
    endtask

    initial
    begin
        logic [7:0]  own;
        logic [15:0] tmo;
        int unsigned p;
        int unsigned target;
        sb = new();
        rst_n <= 1'b0;
        in_w.valid <= 1'b0;
        in_w.req_type <= REQ_TICK;
        in_w.rx_byte <= 8'h00;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        burst_left = 0;
        items_sent = 0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_part();

        p = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            drain();
            cur_role = 1'($urandom_range(0, 1));
            if (p == 0)
                own = 8'h00;
            else if (p == 1)
                own = 8'hFF;
            else
                own = 8'($urandom_range(0, 255));
            if (p == 2)
                tmo = 16'hFFFF;
            else if (p == 3)
                tmo = 16'd1;
            else
                case ($urandom_range(0, 5))
                    0:       tmo = 16'd1;
                    1:       tmo = 16'd2;
                    2:       tmo = 16'hFFFF;
                    3:       tmo = 16'($urandom_range(1, 65535));
                    default: tmo = 16'($urandom_range(3, 8));
                endcase
            write_reg(REG_ROLE, {31'd0, cur_role});
            write_reg(REG_OWN, {24'd0, own});
            write_reg(REG_TIMEOUT, {16'd0, tmo});
            target = items_sent + $urandom_range(80, 200);
            while (items_sent < target)
                run_session();
            p++;
        end

        drain();
        repeat (10)
            @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // downstream stall pattern with occasional long hold-offs
    initial
    begin
        int unsigned hold;
        int unsigned stall_mode;
        int unsigned mode_left;
        int unsigned cyc;
        hold = 0;
        stall_mode = 0;
        mode_left = 0;
        cyc = 0;
        out_w.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold == 0 && (cyc == 600 || cyc == 2500 || $urandom_range(0, 1999) == 0))
                hold = $urandom_range(40, 120);
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold > 0)
            begin
                hold--;
                out_w.ready <= 1'b0;
            end
            else
                case (stall_mode)
                    0:       out_w.ready <= 1'b1;
                    1:       out_w.ready <= 1'($urandom_range(0, 1));
                    2:       out_w.ready <= ($urandom_range(0, 3) == 0);
                    default: out_w.ready <= ((cyc % 3) != 0);
                endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_w.valid && out_w.ready)
            sb.check_word(word_t'{out_w.tx_valid, out_w.tx_byte, out_w.done_res,
                                  out_w.partner_value, out_w.last});
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/shfsm_pkg.sv
rtl/shfsm_in_if.sv
rtl/shfsm_out_if.sv
rtl/shfsm_cfg.sv
rtl/shfsm_core.sv
rtl/shfsm_out.sv
rtl/serial_handshake_fsm_unit.sv
tb/tb_serial_handshake_fsm_unit.sv
